>>> hw/rtl/trzb_pkg.sv
// Package for the triangle rasterizer with depth buffer.
// Holds widths, defaults and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
package trzb_pkg;
    localparam int DefImageWidth  = 1024;
    localparam int DefImageHeight = 1024;
    localparam int CoordW = 10;
    localparam int DepthW = 8;
    localparam int ColorW = 24;
    localparam int CountW = 21;
    localparam int AreaW  = 23;   // doubled area of 10-bit coordinates, signed
    localparam int ProdW  = 32;   // weighted depth sum width
    localparam int DivW   = 9;    // quotient bits produced by the divider

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_AREA,
        ST_BOX,
        ST_EDGE,
        ST_SUM,
        ST_DIV,
        ST_RD,
        ST_TEST,
        ST_NEXT,
        ST_READ,
        ST_READ2,
        ST_OUT
    } state_t;
endpackage

>>> hw/rtl/triangle_rasterizer_zbuffer.sv
// Top level of the triangle rasterizer with depth buffer.
// Depends on trzb_pkg for widths, defaults and the state type.
`timescale 1ns / 1ps
// A request with mode 0 draws a triangle into the color and depth stores and
// returns whether it was culled and how many pixels passed the depth test; a
// request with mode 1 returns the color and depth stored at pixel (ax, ay).
// After reset a clearing pass writes zero to every store entry, one entry a
// cycle, so the block accepts nothing until all 2^(XW+YW) entries, which is
// IMAGE_WIDTH*IMAGE_HEIGHT (1048576 by default) for power-of-two sizes up to
// 1024, are cleared. One shared area unit, one multiply-accumulate unit and
// one restoring divider do the work under a sequencer. After it is accepted,
// a draw works out the area, then the bounding box, then for each pixel of the
// box takes the edge products one after another, the depth products, the
// divider steps, a memory read, the depth test with its write and a step to
// the next pixel; a pixel that fails an edge test or lies in a row below the
// image skips the rest, a column beyond it ends the walk, and a culled draw
// goes straight from the area step to the output. A read passes through ST_READ
// and ST_READ2 to the output state. The result waits in its register for
// m_tready. One request is worked on at a time and s_tready is low meanwhile.
module triangle_rasterizer_zbuffer #(
    parameter int IMAGE_WIDTH  = trzb_pkg::DefImageWidth,
    parameter int IMAGE_HEIGHT = trzb_pkg::DefImageHeight
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, fill_color (lowest first), pad
    input  logic [111:0] s_tdata,
    // mode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // culled, pixels_written, read_color, read_depth (lowest first), pad
    output logic [55:0]  m_tdata
);
    import trzb_pkg::*;

    // Coordinates are CoordW bits wide, so an image wider or taller than that
    // range never needs more address bits than the coordinates carry.
    localparam int XW = ($clog2(IMAGE_WIDTH) > CoordW) ? CoordW : $clog2(IMAGE_WIDTH);
    localparam int YW = ($clog2(IMAGE_HEIGHT) > CoordW) ? CoordW : $clog2(IMAGE_HEIGHT);
    localparam int AddrW = XW + YW;
    localparam int Pixels = 2 ** AddrW;

    // Stores: one word of color and depth per pixel, address y*2^XW + x.
    logic [ColorW+DepthW-1:0] mem [Pixels];
    logic [ColorW+DepthW-1:0] mem_q;
    logic                     mem_we;
    logic [AddrW-1:0]         mem_wa, mem_ra;
    logic [ColorW+DepthW-1:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[mem_ra];
    end

    state_t state_reg, state_next;
    logic signed [CoordW+1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [DepthW-1:0] az_reg, bz_reg, cz_reg;
    logic [ColorW-1:0] col_reg;
    logic [CoordW-1:0] x_reg, x_next, y_reg, y_next, x1_reg, y0_reg, y1_reg;
    logic [CoordW-1:0] x1_next, y0_next, y1_next;
    logic [1:0]        k_reg, k_next;
    logic signed [AreaW-1:0] w_reg [3];
    logic signed [AreaW-1:0] w_next [3];
    logic signed [AreaW-1:0] tot_reg, tot_next;
    logic [ProdW-1:0]  acc_reg, acc_next;
    logic [ProdW-1:0]  rem_reg, rem_next;
    logic [DivW-1:0]   q_reg, q_next;
    logic [3:0]        dc_reg, dc_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic              cull_reg, cull_next, rd_reg, rd_next;
    logic [ColorW+DepthW-1:0] rdat_reg, rdat_next;
    logic [AddrW:0]    clr_reg, clr_next;

    // Shared unit: doubled area of (p, q, r) where p is the pixel or vertex A.
    logic signed [CoordW+1:0] px, py, qx, qy, rx, ry;
    logic signed [AreaW-1:0] area;
    always_comb
    begin
        px = (state_reg == ST_AREA) ? ax_reg : $signed({2'b0, x_reg});
        py = (state_reg == ST_AREA) ? ay_reg : $signed({2'b0, y_reg});
        unique case (k_reg)
            2'd0:    begin qx = bx_reg; qy = by_reg; rx = cx_reg; ry = cy_reg; end
            2'd1:    begin qx = cx_reg; qy = cy_reg; rx = ax_reg; ry = ay_reg; end
            default: begin qx = ax_reg; qy = ay_reg; rx = bx_reg; ry = by_reg; end
        endcase
        if (state_reg == ST_AREA)
        begin
            qx = bx_reg; qy = by_reg; rx = cx_reg; ry = cy_reg;
        end
        area = AreaW'(qy - py) * AreaW'(qx + px) + AreaW'(ry - qy) * AreaW'(rx + qx)
             + AreaW'(py - ry) * AreaW'(px + rx);
    end

    logic [DepthW-1:0] zsel;
    logic [ProdW-1:0]  mac;
    logic [ProdW-1:0]  trial;
    logic [DivW-1:0]   zq;
    always_comb
    begin
        unique case (k_reg)
            2'd0:    zsel = az_reg;
            2'd1:    zsel = bz_reg;
            default: zsel = cz_reg;
        endcase
        mac = acc_reg + ProdW'(unsigned'(w_reg[k_reg])) * ProdW'(zsel);
        trial = {rem_reg[ProdW-2:0], acc_reg[ProdW-1]} - ProdW'(unsigned'(tot_reg));
        zq = q_reg;
    end

    logic in_img;
    assign in_img = (ProdW'(x_reg) < ProdW'(IMAGE_WIDTH))
                 && (ProdW'(y_reg) < ProdW'(IMAGE_HEIGHT));

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg; y_next = y_reg; x1_next = x1_reg;
        y0_next = y0_reg; y1_next = y1_reg; k_next = k_reg;
        w_next = w_reg; tot_next = tot_reg; acc_next = acc_reg;
        rem_next = rem_reg; q_next = q_reg; dc_next = dc_reg;
        cnt_next = cnt_reg; cull_next = cull_reg; rd_next = rd_reg;
        rdat_next = rdat_reg; clr_next = clr_reg;
        mem_we = 1'b0;
        mem_wa = clr_reg[AddrW-1:0];
        mem_wd = '0;
        mem_ra = {y_reg[YW-1:0], x_reg[XW-1:0]};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AddrW+1)'(Pixels - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cnt_next = '0; cull_next = 1'b0; rdat_next = '0;
                    rd_next = s_tuser;
                    x_next = s_tdata[9:0]; y_next = s_tdata[19:10];
                    k_next = 2'd0;
                    state_next = s_tuser ? ST_READ : ST_AREA;
                end
            end
            ST_READ:
            begin
                state_next = ST_READ2;
            end
            ST_READ2:
            begin
                if (in_img)
                begin
                    rdat_next = mem_q;
                end
                state_next = ST_OUT;
            end
            ST_AREA:
            begin
                tot_next = area;
                if (area < 2)
                begin
                    cull_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_BOX;
                end
            end
            ST_BOX:
            begin
                x_next = 10'(ax_reg < bx_reg ? (ax_reg < cx_reg ? ax_reg : cx_reg)
                                             : (bx_reg < cx_reg ? bx_reg : cx_reg));
                x1_next = 10'(ax_reg > bx_reg ? (ax_reg > cx_reg ? ax_reg : cx_reg)
                                              : (bx_reg > cx_reg ? bx_reg : cx_reg));
                y0_next = 10'(ay_reg < by_reg ? (ay_reg < cy_reg ? ay_reg : cy_reg)
                                              : (by_reg < cy_reg ? by_reg : cy_reg));
                y1_next = 10'(ay_reg > by_reg ? (ay_reg > cy_reg ? ay_reg : cy_reg)
                                              : (by_reg > cy_reg ? by_reg : cy_reg));
                y_next = y0_next;
                k_next = 2'd0;
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                // Columns beyond the image end the walk, rows beyond skip on.
                if (ProdW'(x_reg) >= ProdW'(IMAGE_WIDTH))
                begin
                    state_next = ST_OUT;
                end
                else if (!in_img)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    w_next[k_reg] = area;
                    if (area < 0)
                    begin
                        state_next = ST_NEXT;
                    end
                    else if (k_reg == 2'd2)
                    begin
                        k_next = 2'd0;
                        acc_next = '0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                acc_next = mac;
                if (k_reg == 2'd2)
                begin
                    // The quotient fits in DivW bits, so the upper dividend bits
                    // start out in the remainder and only the low DivW bits are
                    // shifted in by the divider.
                    k_next = 2'd0;
                    rem_next = mac >> DivW;
                    acc_next = mac << (ProdW - DivW);
                    q_next = '0;
                    dc_next = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                // Restoring division, one quotient bit a step.
                acc_next = {acc_reg[ProdW-2:0], 1'b0};
                if (!trial[ProdW-1])
                begin
                    rem_next = trial;
                    q_next = {q_reg[DivW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[ProdW-2:0], acc_reg[ProdW-1]};
                    q_next = {q_reg[DivW-2:0], 1'b0};
                end
                dc_next = dc_reg + 1'b1;
                if (dc_reg == 4'd0)
                begin
                    dc_next = 4'd1;
                end
                if (dc_reg == 4'(DivW - 1))
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if ({(DivW-DepthW)'(0), mem_q[DepthW-1:0]} <= zq)
                begin
                    mem_we = 1'b1;
                    mem_wa = {y_reg[YW-1:0], x_reg[XW-1:0]};
                    mem_wd = {col_reg, zq[DepthW-1:0]};
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                k_next = 2'd0;
                state_next = ST_EDGE;
                if (y_reg == y1_reg)
                begin
                    y_next = y0_reg;
                    x_next = x_reg + 1'b1;
                    if (x_reg == x1_reg)
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            k_reg <= '0;
            dc_reg <= '0;
            cnt_reg <= '0;
            cull_reg <= 1'b0;
            rd_reg <= 1'b0;
            rdat_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            k_reg <= k_next;
            dc_reg <= dc_next;
            cnt_reg <= cnt_next;
            cull_reg <= cull_next;
            rd_reg <= rd_next;
            rdat_reg <= rdat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            ax_reg <= $signed({2'b0, s_tdata[9:0]});
            ay_reg <= $signed({2'b0, s_tdata[19:10]});
            az_reg <= s_tdata[27:20];
            bx_reg <= $signed({2'b0, s_tdata[37:28]});
            by_reg <= $signed({2'b0, s_tdata[47:38]});
            bz_reg <= s_tdata[55:48];
            cx_reg <= $signed({2'b0, s_tdata[65:56]});
            cy_reg <= $signed({2'b0, s_tdata[75:66]});
            cz_reg <= s_tdata[83:76];
            col_reg <= s_tdata[107:84];
        end
        x_reg <= x_next; y_reg <= y_next; x1_reg <= x1_next;
        y0_reg <= y0_next; y1_reg <= y1_next;
        w_reg <= w_next; tot_reg <= tot_next; acc_reg <= acc_next;
        rem_reg <= rem_next; q_reg <= q_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {2'b0, rdat_reg[DepthW-1:0], rdat_reg[ColorW+DepthW-1:DepthW],
                      rd_reg ? CountW'(0) : cnt_reg, cull_reg};
endmodule

>>> bench/trzb_tb_pkg.sv
// Shared testbench types for the rasterizer bench: request kinds and result fields.
// Depends on trzb_pkg for the field widths.
`timescale 1ns / 1ps
package trzb_tb_pkg;
    import trzb_pkg::*;

    typedef enum bit {
        MODE_DRAW = 1'b0,
        MODE_READ = 1'b1
    } req_mode_e;

    // Members run from the highest bit down, so culled lands in bit 0.
    typedef struct packed {
        logic [DepthW-1:0] depth;
        logic [ColorW-1:0] color;
        logic [CountW-1:0] pixels;
        logic              culled;
    } raster_result_t;
endpackage

>>> bench/trzb_checker.sv
// Checker for the triangle rasterizer: watches both stream channels, keeps its own
// color and depth stores, predicts each result and compares. Depends on trzb_tb_pkg.
`timescale 1ns / 1ps
module trzb_checker
    import trzb_pkg::*;
    import trzb_tb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [55:0]  m_tdata,
    output int           errors,
    output int           pending
);
    localparam int ImgW = DefImageWidth;
    localparam int ImgH = DefImageHeight;

    bit [DepthW-1:0] depth_mem [0:ImgW*ImgH-1];
    bit [ColorW-1:0] color_mem [0:ImgW*ImgH-1];
    raster_result_t  expected_q [$];

    initial errors = 0;
    assign pending = expected_q.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint doubled_area(input longint px, input longint py,
                                            input longint qx, input longint qy,
                                            input longint rx, input longint ry);
        return (qy - py) * (qx + px) + (ry - qy) * (rx + qx) + (py - ry) * (px + rx);
    endfunction

    // Applies one request to the local stores and returns what the block should answer.
    function automatic raster_result_t render_request(input logic rd, input logic [111:0] d);
        raster_result_t res;
        longint ax, ay, az, bx, by, bz, cx, cy, cz, area, wa, wb, wc, z;
        longint x0, x1, y0, y1;
        logic [ColorW-1:0] col;
        int idx, cnt;
        ax = d[9:0];    ay = d[19:10];  az = d[27:20];
        bx = d[37:28];  by = d[47:38];  bz = d[55:48];
        cx = d[65:56];  cy = d[75:66];  cz = d[83:76];
        col = d[107:84];
        res = '0;
        cnt = 0;
        if (req_mode_e'(rd) == MODE_READ) begin
            if (ax < ImgW && ay < ImgH) begin
                idx = int'(ay) * ImgW + int'(ax);
                res.color = color_mem[idx];
                res.depth = depth_mem[idx];
            end
            return res;
        end
        area = doubled_area(ax, ay, bx, by, cx, cy);
        if (area < 2) begin
            res.culled = 1'b1;
            return res;
        end
        x0 = ax < bx ? ax : bx;  x0 = x0 < cx ? x0 : cx;
        x1 = ax > bx ? ax : bx;  x1 = x1 > cx ? x1 : cx;
        y0 = ay < by ? ay : by;  y0 = y0 < cy ? y0 : cy;
        y1 = ay > by ? ay : by;  y1 = y1 > cy ? y1 : cy;
        for (longint x = x0; x <= x1 && x < ImgW; x++) begin
            for (longint y = y0; y <= y1 && y < ImgH; y++) begin
                wa = doubled_area(x, y, bx, by, cx, cy);
                wb = doubled_area(x, y, cx, cy, ax, ay);
                wc = doubled_area(x, y, ax, ay, bx, by);
                if (wa < 0 || wb < 0 || wc < 0)
                    continue;
                z = (wa * az + wb * bz + wc * cz) / area;
                if (z > 255)
                    z = 255;
                idx = int'(y) * ImgW + int'(x);
                if (z < depth_mem[idx])
                    continue;
                depth_mem[idx] = z[DepthW-1:0];
                color_mem[idx] = col;
                cnt++;
            end
        end
        res.pixels = cnt[CountW-1:0];
        return res;
    endfunction

    always @(posedge clk) begin
        raster_result_t got, want;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                expected_q.push_back(render_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[53:0];
                if (expected_q.size() == 0) begin
                    report("unexpected result", 1, 0);
                end
                else begin
                    want = expected_q.pop_front();
                    if (got.culled !== want.culled)
                        report("culled", got.culled, want.culled);
                    if (got.pixels !== want.pixels)
                        report("pixels_written", got.pixels, want.pixels);
                    if (got.color !== want.color)
                        report("read_color", got.color, want.color);
                    if (got.depth !== want.depth)
                        report("read_depth", got.depth, want.depth);
                end
            end
        end
    end
endmodule

>>> bench/testbench.sv
// Top of the rasterizer bench: clock, reset, request stimulus and result back-pressure.
// Depends on trzb_pkg, trzb_tb_pkg, trzb_checker and the triangle_rasterizer_zbuffer RTL.
`timescale 1ns / 1ps
module testbench;
    import trzb_pkg::*;
    import trzb_tb_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    int           errors;
    int           pending;

    // Burst phases turn off all request gaps so back-to-back traffic is exercised too.
    bit           burst_phase;
    int           stall_left;
    int           hot_x;
    int           hot_y;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    triangle_rasterizer_zbuffer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    trzb_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // Mostly short gaps, now and then a long one; none at all during a burst phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_phase || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // The result side stalls on its own schedule: usually ready, sometimes held
    // off, rarely for a long stretch.
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else begin
            int r;
            r = $urandom_range(0, 99);
            if (!burst_phase && r < 15) begin
                stall_left <= (r < 2) ? $urandom_range(20, 120) : $urandom_range(0, 2);
                m_tready   <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Presents one request and holds it until the block accepts it. The gap is
    // taken before the request so that valid is never dropped and raised again
    // within the same edge.
    task automatic send_request(input req_mode_e kind,
                                input int ax, input int ay, input int az,
                                input int bx, input int by, input int bz,
                                input int cx, input int cy, input int cz,
                                input int color);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, color[23:0], cz[7:0], cy[9:0], cx[9:0], bz[7:0], by[9:0],
                     bx[9:0], az[7:0], ay[9:0], ax[9:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_read(input int x, input int y);
        send_request(MODE_READ, x, y, $urandom_range(0, 255), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), $urandom_range(0, 255),
                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 255), $urandom_range(0, 16777215));
    endtask

    // A random triangle with a small bounding box. Most are turned to face
    // forward so they get drawn; the rest keep whatever winding they had and
    // are often culled. Half land in a small hot area so draws overlap and the
    // depth test goes both ways.
    task automatic send_random_draw();
        int span, bx0, by0, ax, ay, bx, by, cx, cy, t;
        span = ($urandom_range(0, 9) == 0) ? 15 : 7;
        if ($urandom_range(0, 1) == 0) begin
            bx0 = hot_x + $urandom_range(0, 24);
            by0 = hot_y + $urandom_range(0, 24);
        end
        else begin
            bx0 = $urandom_range(0, 1023 - span);
            by0 = $urandom_range(0, 1023 - span);
        end
        ax = bx0 + $urandom_range(0, span);  ay = by0 + $urandom_range(0, span);
        bx = bx0 + $urandom_range(0, span);  by = by0 + $urandom_range(0, span);
        cx = bx0 + $urandom_range(0, span);  cy = by0 + $urandom_range(0, span);
        if ($urandom_range(0, 99) < 85 &&
            (bx - ax) * (cy - ay) - (cx - ax) * (by - ay) < 0) begin
            t = bx;  bx = cx;  cx = t;
            t = by;  by = cy;  cy = t;
        end
        send_request(MODE_DRAW, ax, ay, $urandom_range(0, 255), bx, by,
                     $urandom_range(0, 255), cx, cy, $urandom_range(0, 255),
                     $urandom_range(0, 16777215));
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= MODE_DRAW;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        stall_left  = 0;
        burst_phase = 1'b0;
        hot_x       = $urandom_range(0, 984);
        hot_y       = $urandom_range(0, 984);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Freshly cleared stores read back as zero at both corners.
        send_read(0, 0);
        send_read(1023, 1023);
        // Smallest triangle that is still drawn (doubled area exactly two).
        send_request(MODE_DRAW, 0, 0, 0, 2, 0, 0, 0, 1, 0, 24'h000000);
        send_read(0, 0);
        // Doubled area one, a collinear triangle, and a back-facing one: all culled.
        send_request(MODE_DRAW, 0, 0, 9, 1, 0, 9, 0, 1, 9, 24'h123456);
        send_request(MODE_DRAW, 5, 5, 9, 7, 7, 9, 9, 9, 9, 24'h123456);
        send_request(MODE_DRAW, 0, 0, 9, 0, 6, 9, 6, 0, 9, 24'h123456);
        // Huge back-facing triangles spanning the whole coordinate range are culled cheaply.
        send_request(MODE_DRAW, 0, 0, 255, 1023, 1023, 255, 1023, 0, 255, 24'hFFFFFF);
        send_request(MODE_DRAW, 1023, 1023, 0, 1023, 0, 128, 0, 1023, 255, 24'hFFFFFF);
        // Small front-facing triangle in the far corner with extreme depths and color.
        send_request(MODE_DRAW, 1013, 1013, 255, 1023, 1013, 255, 1013, 1023, 255,
                     24'hFFFFFF);
        send_read(1013, 1013);
        send_read(1023, 1013);
        // A copy with lower depth loses the depth test everywhere; an equal one wins by the tie rule.
        send_request(MODE_DRAW, 1013, 1013, 254, 1023, 1013, 254, 1013, 1023, 254,
                     24'hABCDEF);
        send_request(MODE_DRAW, 1013, 1013, 255, 1023, 1013, 255, 1013, 1023, 255,
                     24'h5A5A5A);
        send_read(1014, 1014);
        // Mixed vertex depths so the interpolated depth varies across the triangle.
        send_request(MODE_DRAW, 100, 200, 0, 115, 200, 255, 100, 215, 128, 24'h00FF00);
        send_read(100, 200);
        send_read(108, 205);
        send_request(MODE_DRAW, 100, 200, 255, 115, 200, 0, 100, 215, 64, 24'hFF0000);
        send_read(108, 205);
        send_read(1023, 0);
        send_read(0, 1023);

        // Random part: draws, reads near recent drawing and anywhere, with
        // burst phases switched on now and then.
        for (int n = 0; n < 1400; n++) begin
            int r;
            if (n % 100 == 0)
                burst_phase = ($urandom_range(0, 3) == 0);
            if (n % 300 == 0) begin
                hot_x = $urandom_range(0, 984);
                hot_y = $urandom_range(0, 984);
            end
            r = $urandom_range(0, 99);
            if (r < 55)
                send_random_draw();
            else if (r < 85)
                send_read(hot_x + $urandom_range(0, 32), hot_y + $urandom_range(0, 32));
            else
                send_read($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        s_tvalid <= 1'b0;

        // Waiting on the clock lets the checker queue the last request before pending is polled.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Clearing pass, about 1400 requests and long stalls on both sides fit well
    // within this.
    initial
    begin
        #1_000_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/trzb_pkg.sv
hw/rtl/triangle_rasterizer_zbuffer.sv
bench/trzb_tb_pkg.sv
bench/trzb_checker.sv
bench/testbench.sv
